FILE: src/pspb_pkg.sv
// Shared types, register indexes and reset values for the pressure setpoint controller.
// No dependencies; every other file refers to this package by scoped names.
package pspb_pkg;

   localparam int ADC_BITS_DEF = 12;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int TARGET_W     = 12;
   localparam int MEAS_W       = 14;
   localparam int STEP_W       = 10;
   localparam int HOLD_W       = 16;
   localparam int BAND_W       = 8;
   localparam int GAIN_W       = 16;
   localparam int OFFSET_W     = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_TICKS = 3'd0,
      CSR_BAND       = 3'd1,
      CSR_TARGET_MAX = 3'd2,
      CSR_SHORT_STEP = 3'd3,
      CSR_LONG_STEP  = 3'd4,
      CSR_ADC_GAIN   = 3'd5,
      CSR_ADC_OFFSET = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [HOLD_W-1:0]          hold_ticks;
      logic [BAND_W-1:0]          hysteresis_band;
      logic [TARGET_W-1:0]        target_max;
      logic [STEP_W-1:0]          short_step;
      logic [STEP_W-1:0]          long_step;
      logic [GAIN_W-1:0]          adc_gain;
      logic signed [OFFSET_W-1:0] adc_offset;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      hold_ticks:      16'd700,
      hysteresis_band: 8'd10,
      target_max:      12'd800,
      short_step:      10'd10,
      long_step:       10'd100,
      adc_gain:        16'd40955,
      adc_offset:      -11'sd129
   };

   localparam logic [TARGET_W-1:0]      TARGET_RESET = 12'd500;
   localparam logic signed [MEAS_W-1:0] MEAS_MIN     = -14'sd1024;
   localparam logic signed [MEAS_W-1:0] MEAS_MAX     = 14'sd5119;

endpackage

FILE: src/pspb_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on pspb_pkg for field widths.
interface pspb_req_if #(
   parameter int ADC_BITS = pspb_pkg::ADC_BITS_DEF
);
   logic                up_pressed;
   logic                down_pressed;
   logic                regulate;
   logic [ADC_BITS-1:0] adc_sample;
   logic                valid;
   logic                ready;

   modport source (output valid, up_pressed, down_pressed, regulate, adc_sample,
                   input ready);
   modport sink   (input valid, up_pressed, down_pressed, regulate, adc_sample,
                   output ready);
endinterface

interface pspb_rsp_if;
   logic                                    relay_on;
   logic [pspb_pkg::TARGET_W-1:0]           target_level;
   logic signed [pspb_pkg::MEAS_W-1:0]      measured_level;
   logic signed [pspb_pkg::MEAS_W-1:0]      shown_level;
   logic                                    regulating;
   logic                                    valid;
   logic                                    ready;

   modport source (output valid, relay_on, target_level, measured_level, shown_level,
                   regulating, input ready);
   modport sink   (input valid, relay_on, target_level, measured_level, shown_level,
                   regulating, output ready);
endinterface

FILE: src/pspb_meas.sv
// Scales a registered ADC product to hundredths of a bar and saturates it.
// Depends on pspb_pkg.
module pspb_meas #(
   parameter int ADC_BITS = pspb_pkg::ADC_BITS_DEF
) (
   input  logic [ADC_BITS+pspb_pkg::GAIN_W-1:0]        product,
   input  logic signed [pspb_pkg::OFFSET_W-1:0]        adc_offset,
   output logic signed [pspb_pkg::MEAS_W-1:0]          measured
);
   localparam int BASE_W = (ADC_BITS > 12) ? ADC_BITS : 12;
   localparam int SUM_W  = BASE_W + 2;

   logic [ADC_BITS-1:0]     scaled;
   logic signed [SUM_W-1:0] scaled_s;
   logic signed [SUM_W-1:0] offset_s;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] min_s;
   logic signed [SUM_W-1:0] max_s;

   always_comb begin
      scaled   = product[ADC_BITS+pspb_pkg::GAIN_W-1:pspb_pkg::GAIN_W];
      scaled_s = SUM_W'($signed({1'b0, scaled}));
      offset_s = SUM_W'(adc_offset);
      sum      = scaled_s + offset_s;
      min_s    = SUM_W'(pspb_pkg::MEAS_MIN);
      max_s    = SUM_W'(pspb_pkg::MEAS_MAX);
      if (sum < min_s) begin
         measured = pspb_pkg::MEAS_MIN;
      end else if (sum > max_s) begin
         measured = pspb_pkg::MEAS_MAX;
      end else begin
         measured = sum[pspb_pkg::MEAS_W-1:0];
      end
   end
endmodule

FILE: src/pspb_button.sv
// One setpoint button: press timer, short and long steps, target clamp.
// Depends on pspb_pkg.
module pspb_button (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            pressed,
   input  logic                            step_down,
   input  logic [pspb_pkg::HOLD_W-1:0]     hold_ticks,
   input  logic [pspb_pkg::STEP_W-1:0]     short_step,
   input  logic [pspb_pkg::STEP_W-1:0]     long_step,
   input  logic [pspb_pkg::TARGET_W-1:0]   target_max,
   input  logic [pspb_pkg::TARGET_W-1:0]   target_in,
   output logic [pspb_pkg::TARGET_W-1:0]   target_out
);
   localparam int T_W = pspb_pkg::TARGET_W + 2;

   logic                          held_ff;
   logic                          held_in;
   logic [pspb_pkg::HOLD_W-1:0]   count_ff;
   logic [pspb_pkg::HOLD_W-1:0]   count_in;
   logic [pspb_pkg::HOLD_W-1:0]   count_inc;
   logic [pspb_pkg::STEP_W-1:0]   step;
   logic signed [T_W-1:0]         delta;
   logic signed [T_W-1:0]         sum;

   always_comb begin
      count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      held_in   = held_ff;
      count_in  = count_ff;
      step      = '0;
      if (pressed) begin
         held_in = 1'b1;
         if (!held_ff) begin
            count_in = '0;
         end else if (count_inc > hold_ticks) begin
            step     = long_step;
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
      end else if (held_ff) begin
         held_in  = 1'b0;
         count_in = count_inc;
         if (count_inc <= hold_ticks) begin
            step = short_step;
         end
      end
      delta = $signed({{(T_W-pspb_pkg::STEP_W){1'b0}}, step});
      if (step_down) begin
         sum = $signed({2'b00, target_in}) - delta;
      end else begin
         sum = $signed({2'b00, target_in}) + delta;
      end
      if (sum < 0) begin
         target_out = '0;
      end else if (sum > $signed({2'b00, target_max})) begin
         target_out = target_max;
      end else begin
         target_out = sum[pspb_pkg::TARGET_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end
endmodule

FILE: src/pressure_setpoint_bang_bang_controller_top.sv
// Pressure setpoint controller with hysteresis relay drive; depends on pspb_pkg,
// pspb_if, pspb_meas and pspb_button.
// Path: a request accepted into the input register loads its response into the
// response register. Throughput: one request per cycle while the response side
// accepts, set by the combinational button and relay update between the registers.
// Synchronous reset restores all configuration registers, target 500, relay off.
module pressure_setpoint_bang_bang_controller_top #(
   parameter int ADC_BITS = pspb_pkg::ADC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [pspb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pspb_pkg::CSR_DATA_W-1:0]   csr_write_data,
   pspb_req_if.sink                          req_chan,
   pspb_rsp_if.source                        rsp_chan
);
   localparam int PROD_W = ADC_BITS + pspb_pkg::GAIN_W;
   localparam int CMP_W  = pspb_pkg::MEAS_W + 2;

   pspb_pkg::cfg_type cfg_ff;

   logic                          s1_valid_ff;
   logic                          s1_up_ff;
   logic                          s1_down_ff;
   logic                          s1_reg_ff;
   logic [PROD_W-1:0]             s1_product_ff;
   logic                          advance;
   logic                          req_take;

   logic [pspb_pkg::TARGET_W-1:0] target_ff;
   logic [pspb_pkg::TARGET_W-1:0] target_mid;
   logic [pspb_pkg::TARGET_W-1:0] target_in;
   logic                          relay_ff;
   logic                          relay_in;
   logic signed [pspb_pkg::MEAS_W-1:0] measured;
   logic signed [CMP_W-1:0]       meas_c;
   logic signed [CMP_W-1:0]       low_c;
   logic signed [CMP_W-1:0]       high_c;

   logic                               rsp_valid_ff;
   logic                               rsp_relay_ff;
   logic [pspb_pkg::TARGET_W-1:0]      rsp_target_ff;
   logic signed [pspb_pkg::MEAS_W-1:0] rsp_meas_ff;
   logic signed [pspb_pkg::MEAS_W-1:0] rsp_shown_ff;
   logic                               rsp_reg_ff;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= pspb_pkg::CFG_RESET;
      end else if (csr_write_en) begin
         case (pspb_pkg::csr_index_type'(csr_index))
            pspb_pkg::CSR_HOLD_TICKS: cfg_ff.hold_ticks <= csr_write_data;
            pspb_pkg::CSR_BAND:
               cfg_ff.hysteresis_band <= csr_write_data[pspb_pkg::BAND_W-1:0];
            pspb_pkg::CSR_TARGET_MAX:
               cfg_ff.target_max <= csr_write_data[pspb_pkg::TARGET_W-1:0];
            pspb_pkg::CSR_SHORT_STEP:
               cfg_ff.short_step <= csr_write_data[pspb_pkg::STEP_W-1:0];
            pspb_pkg::CSR_LONG_STEP:
               cfg_ff.long_step <= csr_write_data[pspb_pkg::STEP_W-1:0];
            pspb_pkg::CSR_ADC_GAIN: cfg_ff.adc_gain <= csr_write_data;
            pspb_pkg::CSR_ADC_OFFSET:
               cfg_ff.adc_offset <= $signed(csr_write_data[pspb_pkg::OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_up_ff      <= req_chan.up_pressed;
         s1_down_ff    <= req_chan.down_pressed;
         s1_reg_ff     <= req_chan.regulate;
         s1_product_ff <= PROD_W'(req_chan.adc_sample) * PROD_W'(cfg_ff.adc_gain);
      end
   end

   pspb_meas #(.ADC_BITS(ADC_BITS)) u_meas (
      .product    (s1_product_ff),
      .adc_offset (cfg_ff.adc_offset),
      .measured   (measured)
   );

   pspb_button u_up (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pressed    (s1_up_ff),
      .step_down  (1'b0),
      .hold_ticks (cfg_ff.hold_ticks),
      .short_step (cfg_ff.short_step),
      .long_step  (cfg_ff.long_step),
      .target_max (cfg_ff.target_max),
      .target_in  (target_ff),
      .target_out (target_mid)
   );

   pspb_button u_down (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .pressed    (s1_down_ff),
      .step_down  (1'b1),
      .hold_ticks (cfg_ff.hold_ticks),
      .short_step (cfg_ff.short_step),
      .long_step  (cfg_ff.long_step),
      .target_max (cfg_ff.target_max),
      .target_in  (target_mid),
      .target_out (target_in)
   );

   always_comb begin
      meas_c   = CMP_W'(measured);
      low_c    = $signed({4'b0000, target_in}) - $signed({8'h00, cfg_ff.hysteresis_band});
      high_c   = $signed({4'b0000, target_in}) + $signed({8'h00, cfg_ff.hysteresis_band});
      relay_in = relay_ff;
      if (s1_reg_ff) begin
         if (meas_c < low_c) begin
            relay_in = 1'b1;
         end else if (meas_c > high_c) begin
            relay_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= pspb_pkg::TARGET_RESET;
         relay_ff  <= 1'b0;
      end else if (advance) begin
         target_ff <= target_in;
         relay_ff  <= relay_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_relay_ff  <= relay_in;
         rsp_target_ff <= target_in;
         rsp_meas_ff   <= measured;
         rsp_shown_ff  <= s1_reg_ff ? measured : $signed({2'b00, target_in});
         rsp_reg_ff    <= s1_reg_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.relay_on       = rsp_relay_ff;
   assign rsp_chan.target_level   = rsp_target_ff;
   assign rsp_chan.measured_level = rsp_meas_ff;
   assign rsp_chan.shown_level    = rsp_shown_ff;
   assign rsp_chan.regulating     = rsp_reg_ff;
endmodule
